[hw/rtl/sha1_stream_hasher_core_assert.svh]
// Assertion macros for the SHA-1 stream hasher
`ifndef SHA1_STREAM_HASHER_CORE_ASSERT_SVH
`define SHA1_STREAM_HASHER_CORE_ASSERT_SVH
// Implication checked on every clock edge outside reset
`define SHA_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Implication whose consequent is checked in the cycle after the antecedent
`define SHA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

[hw/rtl/sha1_pkg.sv]
// ----------------------------------------------------------------------------
// sha1_pkg
// Types and constants shared by the SHA-1 stream hasher modules.
// ----------------------------------------------------------------------------
`default_nettype none
package sha1_pkg;
  localparam logic OP_ABSORB = 1'b0;
  localparam logic OP_FINISH = 1'b1;
  localparam logic [31:0] H0 = 32'h67452301;
  localparam logic [31:0] H1 = 32'hEFCDAB89;
  localparam logic [31:0] H2 = 32'h98BADCFE;
  localparam logic [31:0] H3 = 32'h10325476;
  localparam logic [31:0] H4 = 32'hC3D2E1F0;
  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;
  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [5:0] LEN_OFFSET = 6'd56;

  typedef enum logic [2:0] {
    ST_IDLE, ST_COMP, ST_PAD, ST_OUT
  } state_t;

  typedef enum logic [1:0] {
    SEL_DATA, SEL_PAD, SEL_ZERO, SEL_LEN
  } byte_sel_t;

  // controller -> datapath
  typedef struct packed {
    logic      wr_byte;   // write a byte at the current offset, advance count
    byte_sel_t sel;
    logic      comp_start;
    logic      init;      // reset chain and count
    logic      cap_bits;  // latch bit length
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic       comp_busy;
    logic       comp_done;
    logic [5:0] offset;
  } sts_t;
endpackage
`default_nettype wire

[hw/rtl/sha1_datapath.sv]
// ----------------------------------------------------------------------------
// sha1_datapath
// Block buffer, message schedule, round unit and chaining words.
// ----------------------------------------------------------------------------
`default_nettype none
`include "sha1_stream_hasher_core_assert.svh"
module sha1_datapath import sha1_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire cmd_t        cmd,
  input  wire logic [7:0]  data_byte,
  output sts_t             sts,
  output logic [159:0]     digest
);
  logic [31:0] blk_r [16];
  logic [31:0] cnt_r, cnt_nxt;
  logic [31:0] bits_r;
  logic [31:0] h_r [5];
  logic [31:0] a_r, b_r, c_r, d_r, e_r;
  logic [31:0] w_r [16];
  logic [6:0]  rnd_r;
  logic        busy_r, done_r;
  logic [7:0]  wbyte;
  logic [5:0]  off;
  logic [31:0] f, k, t, wi, wn;

  assign off = cnt_r[5:0];

  always_comb begin
    case (cmd.sel)
      SEL_DATA: wbyte = data_byte;
      SEL_PAD:  wbyte = PAD_BYTE;
      SEL_ZERO: wbyte = 8'h00;
      default: begin
        case (off[1:0])
          2'd0:    wbyte = bits_r[31:24];
          2'd1:    wbyte = bits_r[23:16];
          2'd2:    wbyte = bits_r[15:8];
          default: wbyte = bits_r[7:0];
        endcase
      end
    endcase
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.init) cnt_nxt = '0;
    else if (cmd.wr_byte) cnt_nxt = cnt_r + 32'd1;
  end

  // byte 0 of a word lands in its top bits
  always_ff @(posedge clk) begin
    if (cmd.wr_byte) blk_r[off[5:2]][{~off[1:0], 3'b000} +: 8] <= wbyte;
    if (cmd.cap_bits) bits_r <= {cnt_r[28:0], 3'b000};
  end

  // round logic
  always_comb begin
    if (rnd_r < 7'd20) begin
      f = (b_r & c_r) | (~b_r & d_r); k = K0;
    end else if (rnd_r < 7'd40) begin
      f = b_r ^ c_r ^ d_r; k = K1;
    end else if (rnd_r < 7'd60) begin
      f = (b_r & c_r) | (b_r & d_r) | (c_r & d_r); k = K2;
    end else begin
      f = b_r ^ c_r ^ d_r; k = K3;
    end
    wi = w_r[0];
    wn = w_r[13] ^ w_r[8] ^ w_r[2] ^ w_r[0];
    wn = {wn[30:0], wn[31]};
    t  = {a_r[26:0], a_r[31:27]} + f + e_r + k + wi;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
      rnd_r  <= '0;
      h_r[0] <= H0; h_r[1] <= H1; h_r[2] <= H2; h_r[3] <= H3; h_r[4] <= H4;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= 1'b0;
      if (cmd.init) begin
        h_r[0] <= H0; h_r[1] <= H1; h_r[2] <= H2; h_r[3] <= H3; h_r[4] <= H4;
      end
      if (cmd.comp_start) begin
        busy_r <= 1'b1;
        rnd_r  <= '0;
        a_r <= h_r[0]; b_r <= h_r[1]; c_r <= h_r[2]; d_r <= h_r[3]; e_r <= h_r[4];
        for (int i = 0; i < 16; i++)
          w_r[i] <= blk_r[i];
      end else if (busy_r) begin
        // shift the schedule window by one word
        for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
        w_r[15] <= wn;
        a_r <= t; b_r <= a_r; c_r <= {b_r[1:0], b_r[31:2]}; d_r <= c_r; e_r <= d_r;
        if (rnd_r == 7'd79) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
          h_r[0] <= h_r[0] + t;
          h_r[1] <= h_r[1] + a_r;
          h_r[2] <= h_r[2] + {b_r[1:0], b_r[31:2]};
          h_r[3] <= h_r[3] + c_r;
          h_r[4] <= h_r[4] + d_r;
        end
        rnd_r <= rnd_r + 7'd1;
      end
    end
  end

  assign sts.comp_busy = busy_r;
  assign sts.comp_done = done_r;
  assign sts.offset    = off;
  assign digest = {h_r[4], h_r[3], h_r[2], h_r[1], h_r[0]};

  `SHA_ASSERT_IMP(a_no_wr_busy, busy_r, !cmd.wr_byte, "byte write during compression")
  `SHA_ASSERT_NEXT(a_done_pulse, done_r, !done_r, "done held two cycles")
  `SHA_ASSERT_IMP(a_start_idle, cmd.comp_start, !busy_r, "start while busy")
endmodule
`default_nettype wire

[hw/rtl/sha1_ctrl.sv]
// ----------------------------------------------------------------------------
// sha1_ctrl
// Sequencer for absorb, padding, compression and digest output.
// ----------------------------------------------------------------------------
`default_nettype none
`include "sha1_stream_hasher_core_assert.svh"
module sha1_ctrl import sha1_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  input  wire logic in_op,
  output logic      in_ready,
  output logic      out_valid,
  input  wire logic out_ready,
  output logic      cap_digest,
  input  wire sts_t sts,
  output cmd_t      cmd
);
  state_t st_r, st_nxt;
  logic   fin_r, fin_nxt;   // length field goes into a later block
  logic   pad_r, pad_nxt;   // 0x80 already written
  logic   ov_r, ov_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE; fin_r <= 1'b0; pad_r <= 1'b0; ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt; fin_r <= fin_nxt; pad_r <= pad_nxt; ov_r <= ov_nxt;
    end
  end

  always_comb begin
    st_nxt = st_r; fin_nxt = fin_r; pad_nxt = pad_r; ov_nxt = ov_r;
    cmd = '0; cmd.sel = SEL_DATA;
    in_ready = 1'b0; cap_digest = 1'b0;
    if (ov_r && out_ready) ov_nxt = 1'b0;
    unique case (st_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_op == OP_ABSORB) begin
            cmd.wr_byte = 1'b1;
            if (sts.offset == 6'd63) st_nxt = ST_COMP;
          end else begin
            cmd.cap_bits = 1'b1; pad_nxt = 1'b0; st_nxt = ST_PAD;
          end
        end
      end
      ST_COMP: begin
        if (!sts.comp_busy && !sts.comp_done) cmd.comp_start = 1'b1;
        if (sts.comp_done) begin
          if (fin_r) begin
            fin_nxt = 1'b0; st_nxt = ST_PAD;
          end else if (pad_r) begin
            // the block holding the length field is done
            pad_nxt = 1'b0; st_nxt = ST_OUT;
          end else begin
            st_nxt = ST_IDLE;
          end
        end
      end
      ST_PAD: begin
        cmd.wr_byte = 1'b1;
        if (!pad_r) begin
          cmd.sel = SEL_PAD; pad_nxt = 1'b1;
          // no room left for the length field in this block
          if (sts.offset >= LEN_OFFSET) fin_nxt = 1'b1;
        end else if (!fin_r && sts.offset >= LEN_OFFSET + 6'd4) cmd.sel = SEL_LEN;
        else cmd.sel = SEL_ZERO;
        if (sts.offset == 6'd63) st_nxt = ST_COMP;
      end
      ST_OUT: begin
        if (!ov_r) begin
          cap_digest = 1'b1; ov_nxt = 1'b1; cmd.init = 1'b1;
          fin_nxt = 1'b0; st_nxt = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  assign out_valid = ov_r;

  `SHA_ASSERT_IMP(a_rdy_idle, in_ready, st_r == ST_IDLE, "ready outside idle")
  `SHA_ASSERT_NEXT(a_cap_valid, cap_digest, out_valid, "digest captured but not shown")
  `SHA_ASSERT_IMP(a_cap_free, cap_digest, !ov_r, "digest overwritten")
endmodule
`default_nettype wire

[hw/rtl/sha1_stream_hasher_core.sv]
// ----------------------------------------------------------------------------
// sha1_stream_hasher_core
// SHA-1 hasher taking one byte or a finish command per item.
// ----------------------------------------------------------------------------
// channel | dir | tdata fields (low bit up)              | tuser
// in      | in  | data_byte[7:0]                          | op
// out     | out | digest_word0 .. digest_word4 (160 bits) | -
// Bytes are absorbed while in_tready is high; every 64th byte starts a compression
// (a start step, 80 rounds and a done step) while in_tready is low.
// Finish is taken in idle, then the pad bytes are written one a cycle (9 to 72)
// with one or two compressions, then the output register is loaded once it is free.
// Reset rst_n is synchronous; the digest may wait on out_tready while the
// next message is already absorbed.
`default_nettype none
module sha1_stream_hasher_core import sha1_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [7:0]   in_tdata,   // data_byte
  input  wire logic         in_tuser,   // op
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [159:0]      out_tdata   // digest_word0 .. digest_word4
);
  cmd_t cmd;
  sts_t sts;
  logic cap;
  logic [159:0] dig;
  logic [159:0] out_r;

  sha1_ctrl u_ctrl (
    .clk, .rst_n, .in_valid(in_tvalid), .in_op(in_tuser), .in_ready(in_tready),
    .out_valid(out_tvalid), .out_ready(out_tready), .cap_digest(cap), .sts, .cmd
  );

  sha1_datapath u_dp (
    .clk, .rst_n, .cmd, .data_byte(in_tdata), .sts, .digest(dig)
  );

  always_ff @(posedge clk) begin
    if (cap) out_r <= dig;
  end
  assign out_tdata = out_r;
endmodule
`default_nettype wire
